// ----- src/rvm_pkg.sv -----
`timescale 1ns / 1ps
// rvm_pkg: shared types, fixed-point constants and helpers for the rotation
// vector to matrix converter; no dependencies
package rvm_pkg;

  localparam int SQRT_STEPS   = 32;
  localparam int DIV_STEPS    = 31;
  localparam int CORDIC_STEPS = 30;

  localparam logic signed [35:0] ONE_Q30     = 36'sd1073741824;
  localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [35:0] FOUR_PI_Q30 = 36'sd13493037704;
  localparam logic signed [33:0] CORDIC_K    = 34'sd652032874;

  // request handed from front to back
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [62:0]        sx;
    logic [62:0]        sy;
    logic [62:0]        sz;
    logic               zero;
  } fb_item_t;

  typedef struct packed {
    logic signed [31:0] m00;
    logic signed [31:0] m01;
    logic signed [31:0] m02;
    logic signed [31:0] m10;
    logic signed [31:0] m11;
    logic signed [31:0] m12;
    logic signed [31:0] m20;
    logic signed [31:0] m21;
    logic signed [31:0] m22;
  } res_t;

  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] r;
    case (i)
      5'd0:  r = 30'd843314856;
      5'd1:  r = 30'd497837829;
      5'd2:  r = 30'd263043836;
      5'd3:  r = 30'd133525158;
      5'd4:  r = 30'd67021686;
      5'd5:  r = 30'd33543515;
      5'd6:  r = 30'd16775850;
      5'd7:  r = 30'd8388437;
      5'd8:  r = 30'd4194282;
      5'd9:  r = 30'd2097149;
      5'd10: r = 30'd1048575;
      5'd11: r = 30'd524287;
      5'd12: r = 30'd262143;
      5'd13: r = 30'd131071;
      5'd14: r = 30'd65535;
      5'd15: r = 30'd32767;
      5'd16: r = 30'd16383;
      5'd17: r = 30'd8191;
      5'd18: r = 30'd4095;
      5'd19: r = 30'd2047;
      5'd20: r = 30'd1023;
      5'd21: r = 30'd511;
      5'd22: r = 30'd255;
      5'd23: r = 30'd127;
      5'd24: r = 30'd63;
      5'd25: r = 30'd31;
      5'd26: r = 30'd15;
      5'd27: r = 30'd8;
      5'd28: r = 30'd4;
      5'd29: r = 30'd2;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat_q30(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > ONE_Q30) r = 32'sd1073741824;
    else if (v < -ONE_Q30) r = -32'sd1073741824;
    else r = v[31:0];
    return r;
  endfunction

  // floor((a*b + 2^29) / 2^30)
  function automatic logic signed [32:0] mul_q30(input logic signed [32:0] a,
                                                 input logic signed [32:0] b);
    logic signed [65:0] p;
    p = 66'(a) * 66'(b) + 66'sd536870912;
    return p[62:30];
  endfunction

endpackage

// ----- src/rotation_vector_to_matrix.sv -----
`timescale 1ns / 1ps
// rotation_vector_to_matrix: rotation vector (Q4.28) to 3x3 matrix (Q2.30)
// from the accepting edge to the result showing, an item passes the middle queue
// write, 33 root stages, 32 divider stages, 4 range reduction stages, 31 cordic
// stages, trig, two product stages, output register and result queue write
// throughput one item per cycle; the back pipeline only holds when its output
// register is loaded and the result queue is full; synchronous reset empties all
module rotation_vector_to_matrix #(
  parameter int QUEUE_DEPTH = 4,
  parameter int OUT_DEPTH   = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] rot_x,
  input  logic signed [31:0] rot_y,
  input  logic signed [31:0] rot_z,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] m00,
  output logic signed [31:0] m01,
  output logic signed [31:0] m02,
  output logic signed [31:0] m10,
  output logic signed [31:0] m11,
  output logic signed [31:0] m12,
  output logic signed [31:0] m20,
  output logic signed [31:0] m21,
  output logic signed [31:0] m22
);

  rvm_pkg::fb_item_t fq_wdata;
  rvm_pkg::fb_item_t fq_rdata;
  logic              fq_push;
  logic              fq_full;
  logic              fq_pop;
  logic              fq_empty;
  rvm_pkg::res_t     rq_wdata;
  rvm_pkg::res_t     rq_rdata;
  logic              rq_push;
  logic              rq_full;

  rvm_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .rot_x  (rot_x),
    .rot_y  (rot_y),
    .rot_z  (rot_z),
    .q_push (fq_push),
    .q_full (fq_full),
    .q_data (fq_wdata)
  );

  rvm_fifo #(
    .WIDTH ($bits(rvm_pkg::fb_item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (fq_push),
    .full  (fq_full),
    .wdata (fq_wdata),
    .pop   (fq_pop),
    .empty (fq_empty),
    .rdata (fq_rdata)
  );

  rvm_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_empty (fq_empty),
    .in_pop   (fq_pop),
    .in_data  (fq_rdata),
    .out_push (rq_push),
    .out_full (rq_full),
    .out_data (rq_wdata)
  );

  rvm_fifo #(
    .WIDTH ($bits(rvm_pkg::res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (rq_push),
    .full  (rq_full),
    .wdata (rq_wdata),
    .pop   (pop),
    .empty (empty),
    .rdata (rq_rdata)
  );

  assign m00 = rq_rdata.m00;
  assign m01 = rq_rdata.m01;
  assign m02 = rq_rdata.m02;
  assign m10 = rq_rdata.m10;
  assign m11 = rq_rdata.m11;
  assign m12 = rq_rdata.m12;
  assign m20 = rq_rdata.m20;
  assign m21 = rq_rdata.m21;
  assign m22 = rq_rdata.m22;

endmodule

// ----- src/rvm_fifo.sv -----
`timescale 1ns / 1ps
// rvm_fifo: small first-in first-out queue with push/full and pop/empty
// no package dependencies; DEPTH must be a power of two
module rvm_fifo #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rdata
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW:0]      wr_ptr;
  logic [AW:0]      rd_ptr;

  assign empty = (wr_ptr == rd_ptr);
  assign full  = (wr_ptr[AW-1:0] == rd_ptr[AW-1:0]) && (wr_ptr[AW] != rd_ptr[AW]);
  assign rdata = mem[rd_ptr[AW-1:0]];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr[AW-1:0]] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push && !full) wr_ptr <= wr_ptr + 1'b1;
      if (pop && !empty) rd_ptr <= rd_ptr + 1'b1;
    end
  end

endmodule

// ----- src/rvm_front.sv -----
`timescale 1ns / 1ps
// rvm_front: input register, component squares and zero-vector check
// uses rvm_pkg
module rvm_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic signed [31:0]  rot_x,
  input  logic signed [31:0]  rot_y,
  input  logic signed [31:0]  rot_z,
  output logic                q_push,
  input  logic                q_full,
  output rvm_pkg::fb_item_t   q_data
);

  logic               valid;
  rvm_pkg::fb_item_t  item;
  logic               adv;
  logic signed [63:0] px;
  logic signed [63:0] py;
  logic signed [63:0] pz;

  assign adv    = !valid || !q_full;
  assign full   = !adv;
  assign q_push = valid;
  assign q_data = item;

  assign px = 64'(rot_x) * 64'(rot_x);
  assign py = 64'(rot_y) * 64'(rot_y);
  assign pz = 64'(rot_z) * 64'(rot_z);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (adv) begin
      valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && push) begin
      item.x    <= rot_x;
      item.y    <= rot_y;
      item.z    <= rot_z;
      item.sx   <= px[62:0];
      item.sy   <= py[62:0];
      item.sz   <= pz[62:0];
      item.zero <= (rot_x == 32'sd0) && (rot_y == 32'sd0) && (rot_z == 32'sd0);
    end
  end

endmodule

// ----- src/rvm_back.sv -----
`timescale 1ns / 1ps
// rvm_back: pipelined norm, axis division, cordic sine/cosine and matrix sums
// uses rvm_pkg; every stage advances together unless the output register is loaded and the result queue is full
module rvm_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_empty,
  output logic               in_pop,
  input  rvm_pkg::fb_item_t  in_data,
  output logic               out_push,
  input  logic               out_full,
  output rvm_pkg::res_t      out_data
);

  typedef struct packed {
    logic               valid;
    logic               zero;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [63:0]        n;
    logic [33:0]        rem;
    logic [31:0]        root;
  } sq_t;

  typedef struct packed {
    logic               valid;
    logic               zero;
    logic [31:0]        ang;
    logic [2:0]         sgn;
    logic [2:0][32:0]   rem;
    logic [2:0][30:0]   low;
    logic [2:0][30:0]   q;
  } dv_t;

  typedef struct packed {
    logic                      valid;
    logic                      zero;
    logic [2:0][31:0]          u;
    logic signed [35:0]        a;
    logic                      neg;
  } rd_t;

  typedef struct packed {
    logic                      valid;
    logic                      zero;
    logic [2:0][31:0]          u;
    logic                      neg;
    logic signed [33:0]        x;
    logic signed [33:0]        y;
    logic signed [35:0]        a;
  } cd_t;

  typedef struct packed {
    logic                      valid;
    logic                      zero;
    logic [2:0][31:0]          u;
    logic signed [31:0]        cs;
    logic signed [31:0]        sn;
  } tr_t;

  typedef struct packed {
    logic                      valid;
    logic                      zero;
    logic [2:0][31:0]          u;
    logic signed [31:0]        cs;
    logic [2:0][32:0]          gu;
    logic [2:0][32:0]          su;
  } p1_t;

  typedef struct packed {
    logic                      valid;
    logic                      zero;
    logic signed [31:0]        cs;
    logic [2:0][32:0]          su;
    logic [2:0][32:0]          d;
    logic signed [32:0]        p01;
    logic signed [32:0]        p02;
    logic signed [32:0]        p12;
  } p2_t;

  sq_t  sqp [rvm_pkg::SQRT_STEPS+1];
  dv_t  dvp [rvm_pkg::DIV_STEPS+1];
  rd_t  rdp [4];
  rd_t  rd1_next;
  rd_t  rd2_next;
  rd_t  rd3_next;
  cd_t  cdp [rvm_pkg::CORDIC_STEPS+1];
  tr_t  trs;
  p1_t  p1;
  p2_t  p2;
  logic out_valid;
  logic adv;

  assign adv      = !(out_valid && out_full);
  assign in_pop   = adv && !in_empty;
  assign out_push = out_valid;

  // sum of squares enters the root extraction
  always_ff @(posedge clk) begin
    if (rst) begin
      sqp[0].valid <= 1'b0;
    end else if (adv) begin
      sqp[0].valid <= !in_empty;
      sqp[0].zero  <= in_data.zero;
      sqp[0].x     <= in_data.x;
      sqp[0].y     <= in_data.y;
      sqp[0].z     <= in_data.z;
      sqp[0].n     <= 64'(in_data.sx) + 64'(in_data.sy) + 64'(in_data.sz);
      sqp[0].rem   <= '0;
      sqp[0].root  <= '0;
    end
  end

  // one root bit per stage
  for (genvar k = 0; k < rvm_pkg::SQRT_STEPS; k++) begin : g_sqrt
    sq_t         nxt;
    logic [35:0] t;
    logic [35:0] trial;
    always_comb begin
      nxt   = sqp[k];
      t     = {sqp[k].rem, sqp[k].n[63:62]};
      trial = {2'b00, sqp[k].root, 2'b01};
      nxt.n = {sqp[k].n[61:0], 2'b00};
      if (t >= trial) begin
        nxt.rem  = 34'(t - trial);
        nxt.root = {sqp[k].root[30:0], 1'b1};
      end else begin
        nxt.rem  = t[33:0];
        nxt.root = {sqp[k].root[30:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        sqp[k+1].valid <= 1'b0;
      end else if (adv) begin
        sqp[k+1] <= nxt;
      end
    end
  end

  // divider setup: dividend is |v| * 2^30 + ang/2
  logic [2:0][31:0] mag;
  logic [2:0][61:0] dvd;
  logic [2:0]       sgn0;
  always_comb begin
    sgn0   = {sqp[rvm_pkg::SQRT_STEPS].z[31], sqp[rvm_pkg::SQRT_STEPS].y[31],
              sqp[rvm_pkg::SQRT_STEPS].x[31]};
    mag[0] = sgn0[0] ? 32'(-sqp[rvm_pkg::SQRT_STEPS].x) : sqp[rvm_pkg::SQRT_STEPS].x;
    mag[1] = sgn0[1] ? 32'(-sqp[rvm_pkg::SQRT_STEPS].y) : sqp[rvm_pkg::SQRT_STEPS].y;
    mag[2] = sgn0[2] ? 32'(-sqp[rvm_pkg::SQRT_STEPS].z) : sqp[rvm_pkg::SQRT_STEPS].z;
    for (int i = 0; i < 3; i++) begin
      dvd[i] = {mag[i], 30'd0} + 62'(sqp[rvm_pkg::SQRT_STEPS].root[31:1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dvp[0].valid <= 1'b0;
    end else if (adv) begin
      dvp[0].valid <= sqp[rvm_pkg::SQRT_STEPS].valid;
      dvp[0].zero  <= sqp[rvm_pkg::SQRT_STEPS].zero;
      dvp[0].ang   <= sqp[rvm_pkg::SQRT_STEPS].root;
      dvp[0].sgn   <= sgn0;
      for (int i = 0; i < 3; i++) begin
        dvp[0].rem[i] <= {2'b00, dvd[i][61:31]};
        dvp[0].low[i] <= dvd[i][30:0];
        dvp[0].q[i]   <= '0;
      end
    end
  end

  // one quotient bit per stage, three lanes
  for (genvar k = 0; k < rvm_pkg::DIV_STEPS; k++) begin : g_div
    dv_t         nxt;
    logic [33:0] t [3];
    always_comb begin
      nxt = dvp[k];
      for (int i = 0; i < 3; i++) begin
        t[i]       = {dvp[k].rem[i], dvp[k].low[i][30]};
        nxt.low[i] = {dvp[k].low[i][29:0], 1'b0};
        if (t[i] >= {2'b00, dvp[k].ang}) begin
          nxt.rem[i] = 33'(t[i] - {2'b00, dvp[k].ang});
          nxt.q[i]   = {dvp[k].q[i][29:0], 1'b1};
        end else begin
          nxt.rem[i] = t[i][32:0];
          nxt.q[i]   = {dvp[k].q[i][29:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dvp[k+1].valid <= 1'b0;
      end else if (adv) begin
        dvp[k+1] <= nxt;
      end
    end
  end

  // range reduction of the angle to [-pi/2, pi/2]
  always_comb begin
    rd1_next = rdp[0];
    if (rdp[0].a >= rvm_pkg::FOUR_PI_Q30) begin
      rd1_next.a = rdp[0].a - rvm_pkg::FOUR_PI_Q30;
    end else if (rdp[0].a >= rvm_pkg::TWO_PI_Q30) begin
      rd1_next.a = rdp[0].a - rvm_pkg::TWO_PI_Q30;
    end

    rd2_next = rdp[1];
    if (rdp[1].a > rvm_pkg::PI_Q30) begin
      rd2_next.a = rdp[1].a - rvm_pkg::TWO_PI_Q30;
    end

    rd3_next = rdp[2];
    if (rdp[2].a > rvm_pkg::HALF_PI_Q30) begin
      rd3_next.a   = rdp[2].a - rvm_pkg::PI_Q30;
      rd3_next.neg = 1'b1;
    end else if (rdp[2].a < -rvm_pkg::HALF_PI_Q30) begin
      rd3_next.a   = rdp[2].a + rvm_pkg::PI_Q30;
      rd3_next.neg = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rdp[0].valid <= 1'b0;
      rdp[1].valid <= 1'b0;
      rdp[2].valid <= 1'b0;
      rdp[3].valid <= 1'b0;
    end else if (adv) begin
      rdp[0].valid <= dvp[rvm_pkg::DIV_STEPS].valid;
      rdp[0].zero  <= dvp[rvm_pkg::DIV_STEPS].zero;
      rdp[0].neg   <= 1'b0;
      rdp[0].a     <= $signed({2'b00, dvp[rvm_pkg::DIV_STEPS].ang, 2'b00});
      for (int i = 0; i < 3; i++) begin
        rdp[0].u[i] <= dvp[rvm_pkg::DIV_STEPS].sgn[i] ?
                       32'(-{1'b0, dvp[rvm_pkg::DIV_STEPS].q[i]}) :
                       {1'b0, dvp[rvm_pkg::DIV_STEPS].q[i]};
      end
      rdp[1] <= rd1_next;
      rdp[2] <= rd2_next;
      rdp[3] <= rd3_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cdp[0].valid <= 1'b0;
    end else if (adv) begin
      cdp[0].valid <= rdp[3].valid;
      cdp[0].zero  <= rdp[3].zero;
      cdp[0].u     <= rdp[3].u;
      cdp[0].neg   <= rdp[3].neg;
      cdp[0].x     <= rvm_pkg::CORDIC_K;
      cdp[0].y     <= '0;
      cdp[0].a     <= rdp[3].a;
    end
  end

  for (genvar k = 0; k < rvm_pkg::CORDIC_STEPS; k++) begin : g_cordic
    cd_t                nxt;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [35:0] at;
    always_comb begin
      nxt = cdp[k];
      dx  = cdp[k].y >>> k;
      dy  = cdp[k].x >>> k;
      at  = $signed({6'd0, rvm_pkg::atan_q30(5'(k))});
      if (cdp[k].a >= 36'sd0) begin
        nxt.x = cdp[k].x - dx;
        nxt.y = cdp[k].y + dy;
        nxt.a = cdp[k].a - at;
      end else begin
        nxt.x = cdp[k].x + dx;
        nxt.y = cdp[k].y - dy;
        nxt.a = cdp[k].a + at;
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        cdp[k+1].valid <= 1'b0;
      end else if (adv) begin
        cdp[k+1] <= nxt;
      end
    end
  end

  logic signed [31:0] cs_sat;
  logic signed [31:0] sn_sat;
  logic signed [32:0] g;
  assign cs_sat = rvm_pkg::sat_q30(36'(cdp[rvm_pkg::CORDIC_STEPS].x));
  assign sn_sat = rvm_pkg::sat_q30(36'(cdp[rvm_pkg::CORDIC_STEPS].y));
  assign g      = 33'sd1073741824 - 33'(trs.cs);

  // matrix sums, 36 bits before saturation
  logic signed [35:0] e [9];
  always_comb begin
    e[0] = 36'(p2.cs) + 36'($signed(p2.d[0]));
    e[1] = 36'(p2.p01) - 36'($signed(p2.su[2]));
    e[2] = 36'($signed(p2.su[1])) + 36'(p2.p02);
    e[3] = 36'($signed(p2.su[2])) + 36'(p2.p01);
    e[4] = 36'(p2.cs) + 36'($signed(p2.d[1]));
    e[5] = 36'(p2.p12) - 36'($signed(p2.su[0]));
    e[6] = 36'(p2.p02) - 36'($signed(p2.su[1]));
    e[7] = 36'($signed(p2.su[0])) + 36'(p2.p12);
    e[8] = 36'(p2.cs) + 36'($signed(p2.d[2]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trs.valid <= 1'b0;
      p1.valid  <= 1'b0;
      p2.valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      trs.valid <= cdp[rvm_pkg::CORDIC_STEPS].valid;
      trs.zero  <= cdp[rvm_pkg::CORDIC_STEPS].zero;
      trs.u     <= cdp[rvm_pkg::CORDIC_STEPS].u;
      trs.cs    <= cdp[rvm_pkg::CORDIC_STEPS].neg ? -cs_sat : cs_sat;
      trs.sn    <= cdp[rvm_pkg::CORDIC_STEPS].neg ? -sn_sat : sn_sat;

      p1.valid <= trs.valid;
      p1.zero  <= trs.zero;
      p1.u     <= trs.u;
      p1.cs    <= trs.cs;
      for (int i = 0; i < 3; i++) begin
        p1.gu[i] <= rvm_pkg::mul_q30(g, 33'($signed(trs.u[i])));
        p1.su[i] <= rvm_pkg::mul_q30(33'(trs.sn), 33'($signed(trs.u[i])));
      end

      p2.valid <= p1.valid;
      p2.zero  <= p1.zero;
      p2.cs    <= p1.cs;
      p2.su    <= p1.su;
      for (int i = 0; i < 3; i++) begin
        p2.d[i] <= rvm_pkg::mul_q30($signed(p1.gu[i]), 33'($signed(p1.u[i])));
      end
      p2.p01 <= rvm_pkg::mul_q30($signed(p1.gu[0]), 33'($signed(p1.u[1])));
      p2.p02 <= rvm_pkg::mul_q30($signed(p1.gu[0]), 33'($signed(p1.u[2])));
      p2.p12 <= rvm_pkg::mul_q30($signed(p1.gu[1]), 33'($signed(p1.u[2])));

      out_valid <= p2.valid;
      if (p2.zero) begin
        out_data.m00 <= 32'sd1073741824;
        out_data.m01 <= '0;
        out_data.m02 <= '0;
        out_data.m10 <= '0;
        out_data.m11 <= 32'sd1073741824;
        out_data.m12 <= '0;
        out_data.m20 <= '0;
        out_data.m21 <= '0;
        out_data.m22 <= 32'sd1073741824;
      end else begin
        out_data.m00 <= rvm_pkg::sat_q30(e[0]);
        out_data.m01 <= rvm_pkg::sat_q30(e[1]);
        out_data.m02 <= rvm_pkg::sat_q30(e[2]);
        out_data.m10 <= rvm_pkg::sat_q30(e[3]);
        out_data.m11 <= rvm_pkg::sat_q30(e[4]);
        out_data.m12 <= rvm_pkg::sat_q30(e[5]);
        out_data.m20 <= rvm_pkg::sat_q30(e[6]);
        out_data.m21 <= rvm_pkg::sat_q30(e[7]);
        out_data.m22 <= rvm_pkg::sat_q30(e[8]);
      end
    end
  end

endmodule

// ----- verif/rvm_checker.sv -----
`timescale 1ns / 1ps
// rvm_checker: watches both queue sides of rotation_vector_to_matrix, predicts
// each matrix from the accepted rotation vector and compares; uses rvm_pkg
module rvm_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic               full,
  input  logic signed [31:0] rot_x,
  input  logic signed [31:0] rot_y,
  input  logic signed [31:0] rot_z,
  input  logic               empty,
  input  logic               pop,
  input  logic signed [31:0] m00,
  input  logic signed [31:0] m01,
  input  logic signed [31:0] m02,
  input  logic signed [31:0] m10,
  input  logic signed [31:0] m11,
  input  logic signed [31:0] m12,
  input  logic signed [31:0] m20,
  input  logic signed [31:0] m21,
  input  logic signed [31:0] m22,
  output int                 errors,
  output int                 pending
);

  localparam longint ONE  = 64'sd1073741824;
  localparam longint HALF = 64'sd536870912;

  const longint arctan_q30[30] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
    65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31,
    15, 8, 4, 2};

  rvm_pkg::res_t matrix_q[$];

  function automatic longint clamp_one(longint v);
    if (v > ONE) return ONE;
    if (v < -ONE) return -ONE;
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return (a * b + HALF) >>> 30;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint axis_q30(longint v, longint unsigned ang);
    longint unsigned mag, q;
    mag = (v < 0) ? longint'(-v) : longint'(v);
    q = ((mag << 30) + (ang >> 1)) / ang;
    return (v < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic rvm_pkg::res_t predict_matrix(logic signed [31:0] vx,
                                                   logic signed [31:0] vy,
                                                   logic signed [31:0] vz);
    longint v[3], u[3], m[9];
    longint a, x, y, nx, dx, dy, cs, sn, g, g0, g1, g2, p01, p02, p12;
    longint unsigned sq, ang;
    bit flip;
    rvm_pkg::res_t r;
    v[0] = vx;
    v[1] = vy;
    v[2] = vz;
    sq = 0;
    for (int i = 0; i < 3; i++) sq += longint'(v[i] * v[i]);
    if (sq == 0) begin
      foreach (m[i]) m[i] = 0;
      m[0] = ONE;
      m[4] = ONE;
      m[8] = ONE;
    end else begin
      ang = root_floor(sq);
      for (int i = 0; i < 3; i++) u[i] = axis_q30(v[i], ang);
      // reduce to (-pi, pi], then fold into the cordic range
      a = longint'(ang << 2);
      flip = 0;
      while (a >= longint'(rvm_pkg::TWO_PI_Q30)) a -= longint'(rvm_pkg::TWO_PI_Q30);
      if (a > longint'(rvm_pkg::PI_Q30)) a -= longint'(rvm_pkg::TWO_PI_Q30);
      if (a > longint'(rvm_pkg::HALF_PI_Q30)) begin
        a -= longint'(rvm_pkg::PI_Q30);
        flip = 1;
      end else if (a < -longint'(rvm_pkg::HALF_PI_Q30)) begin
        a += longint'(rvm_pkg::PI_Q30);
        flip = 1;
      end
      x = longint'(rvm_pkg::CORDIC_K);
      y = 0;
      for (int i = 0; i < 30; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (a >= 0) begin
          nx = x - dx; y = y + dy; a -= arctan_q30[i];
        end else begin
          nx = x + dx; y = y - dy; a += arctan_q30[i];
        end
        x = nx;
      end
      cs = clamp_one(x);
      sn = clamp_one(y);
      if (flip) begin
        cs = -cs;
        sn = -sn;
      end
      g = ONE - cs;
      g0 = qmul(g, u[0]);
      g1 = qmul(g, u[1]);
      g2 = qmul(g, u[2]);
      p01 = qmul(g0, u[1]);
      p02 = qmul(g0, u[2]);
      p12 = qmul(g1, u[2]);
      m[0] = cs + qmul(g0, u[0]);
      m[1] = -qmul(sn, u[2]) + p01;
      m[2] = qmul(sn, u[1]) + p02;
      m[3] = qmul(sn, u[2]) + p01;
      m[4] = cs + qmul(g1, u[1]);
      m[5] = -qmul(sn, u[0]) + p12;
      m[6] = -qmul(sn, u[1]) + p02;
      m[7] = qmul(sn, u[0]) + p12;
      m[8] = cs + qmul(g2, u[2]);
    end
    foreach (m[i]) m[i] = clamp_one(m[i]);
    r.m00 = m[0][31:0]; r.m01 = m[1][31:0]; r.m02 = m[2][31:0];
    r.m10 = m[3][31:0]; r.m11 = m[4][31:0]; r.m12 = m[5][31:0];
    r.m20 = m[6][31:0]; r.m21 = m[7][31:0]; r.m22 = m[8][31:0];
    return r;
  endfunction

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    rvm_pkg::res_t want;
    logic signed [31:0] got [9];
    logic signed [31:0] exp_v [9];
    if (!rst) begin
      if (push && !full) matrix_q.push_back(predict_matrix(rot_x, rot_y, rot_z));
      if (pop && !empty) begin
        if (matrix_q.size() == 0) begin
          $display("%0t: result with no request waiting", $time);
          errors++;
        end else begin
          want = matrix_q.pop_front();
          got = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};
          exp_v = '{want.m00, want.m01, want.m02, want.m10, want.m11, want.m12,
                    want.m20, want.m21, want.m22};
          for (int i = 0; i < 9; i++)
            if (got[i] !== exp_v[i]) begin
              $display("%0t: m%0d%0d expected %0d actual %0d", $time, i / 3, i % 3,
                       exp_v[i], got[i]);
              errors++;
            end
        end
      end
      pending <= matrix_q.size();
    end
  end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// tb: stimulus and verdict for rotation_vector_to_matrix; prediction and
// comparison live in rvm_checker; depends on rvm_pkg and the block
module tb;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 400;
  localparam int PI_Q28         = 843314856;

  logic clk = 0;
  logic rst = 1;
  logic push = 0;
  logic pop = 0;
  logic signed [31:0] rot_x = 0, rot_y = 0, rot_z = 0;
  logic full, empty;
  logic signed [31:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  int errors, pending;
  int idle_cycles = 0;
  int cycle = 0;

  always #1 clk = ~clk;

  rotation_vector_to_matrix dut (.*);
  rvm_checker chk (.*);

  // receiver: own stall pattern plus one long hold-off
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle >= 300 && cycle < 300 + HOLD_CYCLES) pop <= 0;
    else if ((cycle / 64) % 3 == 0) pop <= 1;
    else pop <= ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_vector(logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] z);
    push <= 1;
    rot_x <= x;
    rot_y <= y;
    rot_z <= z;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_component(int kind);
    logic signed [31:0] r;
    case (kind)
      0: r = $urandom();
      1: r = $signed($urandom_range(0, 2000)) - 1000;
      2: r = $signed($urandom_range(0, 1 << 29)) - (1 << 28);
      default: r = (($urandom_range(0, 1) != 0) ? -1 : 1) *
                   (PI_Q28 + $signed($urandom_range(0, 64)) - 32);
    endcase
    return r;
  endfunction

  initial begin
    int kind, burst;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // zero vector, single and all axes at both extremes, tiny values, angles near pi, pi/2 and 2pi, a mixed vector
    send_vector(0, 0, 0);
    send_vector(32'h7fffffff, 0, 0);
    send_vector(32'sh80000000, 0, 0);
    send_vector(0, 32'h7fffffff, 0);
    send_vector(0, 32'sh80000000, 0);
    send_vector(0, 0, 32'h7fffffff);
    send_vector(0, 0, 32'sh80000000);
    send_vector(32'sh80000000, 32'sh80000000, 32'sh80000000);
    send_vector(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_vector(1, 0, 0);
    send_vector(0, -1, 0);
    send_vector(0, 0, 1);
    send_vector(-1, -1, -1);
    send_vector(PI_Q28, 0, 0);
    send_vector(0, -PI_Q28, 0);
    send_vector(0, 0, PI_Q28 / 2);
    send_vector(0, 0, PI_Q28 / 2 + 1);
    send_vector(2 * PI_Q28, 0, 0);
    send_vector(-32'sh55555555, 32'sh55555555, -32'sh2aaaaaaa);
    push <= 0;

    // sender pauses until everything has drained
    wait (pending == 0);
    @(posedge clk);

    for (int n = 0; n < 750; ) begin
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst; b++, n++) begin
        kind = $urandom_range(0, 3);
        send_vector(rand_component(kind), rand_component(kind), rand_component(kind));
      end
      if ($urandom_range(0, 2) != 0) begin
        push <= 0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
    push <= 0;

    wait (pending == 0);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
